// ===== rtl/core/arpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// arpcr_pkg
// Shared types and constants of the ARP cache resolver.
// ----------------------------------------------------------------------------
package arpcr_pkg;

  // Default sizes of the address table and the pending-packet queue.
  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned QueueDepthDef   = 16;

  // Action codes of a command.
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_RX   = 2'd1;
  localparam logic [1:0] ACT_TX   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_REPLY   = 2'd1;
  localparam logic [1:0] KIND_FORWARD = 2'd2;

  // Expected ARP header values.
  localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
  localparam logic [15:0] ARP_PTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  ARP_HLEN       = 8'd6;
  localparam logic [7:0]  ARP_PLEN       = 8'd4;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_LOCAL_IP  = 2'd0;
  localparam logic [1:0] REG_LOCAL_MAC = 2'd1;
  localparam logic [1:0] REG_LIFETIME  = 2'd2;

  localparam logic [15:0] LIFETIME_RESET = 16'd60;

  // Word widths of the two stores.
  localparam int unsigned TableWordW = 112;
  localparam int unsigned QueueWordW = 56;

  // One result frame.
  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [7:0]  tag;
    logic [15:0] protocol;
  } result_t;

endpackage

// ===== rtl/core/arpcr_ram.sv =====
// ----------------------------------------------------------------------------
// arpcr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module arpcr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/arp_cache_resolver_unit.sv =====
// ----------------------------------------------------------------------------
// arp_cache_resolver_unit
// ARP resolver with an aging address table and a pending-packet queue.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high until
// the cycle in which the last result of the command is on the result ports. A
// tick only advances the seconds counter. A received ARP packet with a valid
// header runs the aging scan over every table entry, learns the sender, then
// walks the queue: each queued packet is read and looked up in the table entry
// by entry, and the walk stops at the first free queue slot or after the last
// one, then finishes; an outgoing packet is looked up in the table and, on a
// miss, the queue is scanned for a free slot. One table read port is visited
// one entry at a time. Results leave one per cycle on result_valid_o and the
// receiver cannot stall them; last_o marks the final result of a command.
module arp_cache_resolver_unit
  import arpcr_pkg::*;
#(
  parameter int unsigned TableEntries = TableEntriesDef,
  parameter int unsigned QueueDepth   = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [15:0] hw_type_i,
  input  logic [15:0] proto_type_i,
  input  logic [7:0]  hw_len_i,
  input  logic [7:0]  proto_len_i,
  input  logic [15:0] arp_op_i,
  input  logic [31:0] src_ip_i,
  input  logic [47:0] src_mac_i,
  input  logic [31:0] asked_ip_i,
  input  logic [31:0] dest_ip_i,
  input  logic [7:0]  packet_tag_i,
  input  logic [15:0] upper_protocol_i,
  // Result channel
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [47:0] out_mac_o,
  output logic [31:0] out_ip_o,
  output logic [7:0]  out_tag_o,
  output logic [15:0] out_protocol_o,
  output logic        last_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned TIW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned QIW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_AGE_ADDR  = 10'b00_0000_0010,
    S_AGE_DATA  = 10'b00_0000_0100,
    S_LEARN     = 10'b00_0000_1000,
    S_WALK_CHK  = 10'b00_0001_0000,
    S_WALK_DATA = 10'b00_0010_0000,
    S_LK_ADDR   = 10'b00_0100_0000,
    S_LK_DATA   = 10'b00_1000_0000,
    S_QSCAN     = 10'b01_0000_0000,
    S_FINISH    = 10'b10_0000_0000
  } state_e;

  // Configuration registers.
  logic [31:0] local_ip_q;
  logic [47:0] local_mac_q;
  logic [15:0] lifetime_q;

  // Control state.
  state_e                  state_q, state_d;
  logic [31:0]             sec_q, sec_d;
  logic [TableEntries-1:0] valid_q, valid_d;
  logic [TableEntries-1:0] written_q, written_d;
  logic [QueueDepth-1:0]   pvalid_q, pvalid_d;
  logic                    found_free_q, found_free_d;
  logic                    mode_tx_q, mode_tx_d;
  logic                    held_v_q, held_v_d;
  logic                    res_valid_q, res_valid_d;
  logic                    res_last_q, res_last_d;

  // Payload registers.
  logic [TIW-1:0] tidx_q, tidx_d;
  logic [QIW-1:0] qidx_q, qidx_d;
  logic [TIW-1:0] free_slot_q, free_slot_d;
  logic [TIW-1:0] oldest_q, oldest_d;
  logic [31:0]    oldest_age_q, oldest_age_d;
  logic [31:0]    key_q, key_d;
  logic [31:0]    sip_q, sip_d;
  logic [47:0]    smac_q, smac_d;
  logic [31:0]    aip_q, aip_d;
  logic           is_req_q, is_req_d;
  logic [7:0]     ptag_q, ptag_d;
  logic [15:0]    pproto_q, pproto_d;
  result_t        held_q, held_d;
  result_t        res_q, res_d;

  // Store ports.
  logic                  tab_we;
  logic [TIW-1:0]        tab_waddr;
  logic [TableWordW-1:0] tab_wdata, tab_rdata;
  logic                  q_we;
  logic [QueueWordW-1:0] q_wdata, q_rdata;

  arpcr_ram #(.Width(TableWordW), .Depth(TableEntries)) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i (tidx_q),
    .rdata_o (tab_rdata)
  );

  arpcr_ram #(.Width(QueueWordW), .Depth(QueueDepth)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (qidx_q),
    .wdata_i (q_wdata),
    .raddr_i (qidx_q),
    .rdata_o (q_rdata)
  );

  // Configuration port: writes complete in the access phase.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q  <= '0;
      local_mac_q <= '0;
      lifetime_q  <= LIFETIME_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_LOCAL_IP:  local_ip_q  <= pwdata[31:0];
        REG_LOCAL_MAC: local_mac_q <= pwdata[47:0];
        REG_LIFETIME:  lifetime_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_LOCAL_IP:  prdata = {32'd0, local_ip_q};
      REG_LOCAL_MAC: prdata = {16'd0, local_mac_q};
      REG_LIFETIME:  prdata = {48'd0, lifetime_q};
      default:       prdata = '0;
    endcase
  end

  // Fields of the table word; a never-written entry has a stamp of zero.
  logic [31:0] tab_ip, tab_stamp, age;
  logic [47:0] tab_mac;
  logic        t_last, q_last, hdr_ok;
  assign tab_ip    = tab_rdata[111:80];
  assign tab_mac   = tab_rdata[79:32];
  assign tab_stamp = written_q[tidx_q] ? tab_rdata[31:0] : 32'd0;
  assign age       = sec_q - tab_stamp;
  assign t_last    = (tidx_q == TIW'(TableEntries - 1));
  assign q_last    = (qidx_q == QIW'(QueueDepth - 1));
  assign hdr_ok    = (hw_type_i == ARP_HTYPE_ETH) && (proto_type_i == ARP_PTYPE_IPV4) &&
                     (hw_len_i == ARP_HLEN) && (proto_len_i == ARP_PLEN) &&
                     ((arp_op_i == ARP_OP_REQUEST) || (arp_op_i == ARP_OP_REPLY));

  // Sequencer. A new result goes to the hold register, and the one held
  // before it is sent without the last flag.
  always_comb begin
    result_t nr;
    logic    produce;
    logic    expire;
    logic    hit;
    logic [TIW-1:0] slot;

    state_d      = state_q;
    sec_d        = sec_q;
    valid_d      = valid_q;
    written_d    = written_q;
    pvalid_d     = pvalid_q;
    found_free_d = found_free_q;
    mode_tx_d    = mode_tx_q;
    held_v_d     = held_v_q;
    res_valid_d  = 1'b0;
    res_last_d   = 1'b0;
    tidx_d       = tidx_q;
    qidx_d       = qidx_q;
    free_slot_d  = free_slot_q;
    oldest_d     = oldest_q;
    oldest_age_d = oldest_age_q;
    key_d        = key_q;
    sip_d        = sip_q;
    smac_d       = smac_q;
    aip_d        = aip_q;
    is_req_d     = is_req_q;
    ptag_d       = ptag_q;
    pproto_d     = pproto_q;
    held_d       = held_q;
    res_d        = res_q;
    tab_we       = 1'b0;
    tab_waddr    = tidx_q;
    tab_wdata    = {sip_q, smac_q, sec_q};
    q_we         = 1'b0;
    q_wdata      = {key_q, ptag_q, pproto_q};
    nr           = '0;
    produce      = 1'b0;
    expire       = age > {16'd0, lifetime_q};
    hit          = valid_q[tidx_q] && (tab_ip == key_q);
    slot         = found_free_q ? free_slot_q : oldest_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          sip_d        = src_ip_i;
          smac_d       = src_mac_i;
          aip_d        = asked_ip_i;
          is_req_d     = (arp_op_i == ARP_OP_REQUEST);
          key_d        = dest_ip_i;
          ptag_d       = packet_tag_i;
          pproto_d     = upper_protocol_i;
          tidx_d       = '0;
          qidx_d       = '0;
          found_free_d = 1'b0;
          case (action_i)
            ACT_TICK: sec_d = sec_q + 32'd1;
            ACT_RX: begin
              if (hdr_ok) begin
                state_d = S_AGE_ADDR;
              end
            end
            ACT_TX: begin
              mode_tx_d = 1'b1;
              state_d   = S_LK_ADDR;
            end
            default: ;
          endcase
        end
      end

      S_AGE_ADDR: state_d = S_AGE_DATA;

      // Expire old entries, note the first free slot and the oldest one.
      S_AGE_DATA: begin
        if (expire) begin
          valid_d[tidx_q] = 1'b0;
        end
        if (!found_free_q && (!valid_q[tidx_q] || expire)) begin
          found_free_d = 1'b1;
          free_slot_d  = tidx_q;
        end
        if ((tidx_q == '0) || (age > oldest_age_q)) begin
          oldest_d     = tidx_q;
          oldest_age_d = age;
        end
        if (t_last) begin
          state_d = S_LEARN;
        end else begin
          tidx_d  = tidx_q + TIW'(1);
          state_d = S_AGE_ADDR;
        end
      end

      S_LEARN: begin
        tab_we          = 1'b1;
        tab_waddr       = slot;
        valid_d[slot]   = 1'b1;
        written_d[slot] = 1'b1;
        mode_tx_d       = 1'b0;
        qidx_d          = '0;
        state_d         = S_WALK_CHK;
      end

      // Walk the queue until the first free slot or past the last one.
      S_WALK_CHK: begin
        if (!pvalid_q[qidx_q]) begin
          if (is_req_q && (aip_q == local_ip_q)) begin
            produce     = 1'b1;
            nr.kind     = KIND_REPLY;
            nr.mac      = smac_q;
            nr.ip       = sip_q;
          end
          state_d = S_FINISH;
        end else begin
          state_d = S_WALK_DATA;
        end
      end

      S_WALK_DATA: begin
        key_d    = q_rdata[55:24];
        ptag_d   = q_rdata[23:16];
        pproto_d = q_rdata[15:0];
        tidx_d   = '0;
        state_d  = S_LK_ADDR;
      end

      S_LK_ADDR: state_d = S_LK_DATA;

      // Table lookup, first valid match wins.
      S_LK_DATA: begin
        if (hit || t_last) begin
          if (hit) begin
            produce     = 1'b1;
            nr.kind     = KIND_FORWARD;
            nr.mac      = tab_mac;
            nr.tag      = ptag_q;
            nr.protocol = pproto_q;
          end
          if (mode_tx_q) begin
            qidx_d  = '0;
            state_d = hit ? S_FINISH : S_QSCAN;
          end else begin
            if (hit) begin
              pvalid_d[qidx_q] = 1'b0;
            end
            if (q_last) begin
              state_d = S_FINISH;
            end else begin
              qidx_d  = qidx_q + QIW'(1);
              state_d = S_WALK_CHK;
            end
          end
        end else begin
          tidx_d  = tidx_q + TIW'(1);
          state_d = S_LK_ADDR;
        end
      end

      // Miss on an outgoing packet: queue it if there is room, then request.
      S_QSCAN: begin
        if (!pvalid_q[qidx_q] || q_last) begin
          if (!pvalid_q[qidx_q]) begin
            q_we             = 1'b1;
            pvalid_d[qidx_q] = 1'b1;
          end
          produce = 1'b1;
          nr.kind = KIND_REQUEST;
          nr.mac  = BCAST_MAC;
          nr.ip   = key_q;
          state_d = S_FINISH;
        end else begin
          qidx_d = qidx_q + QIW'(1);
        end
      end

      S_FINISH: begin
        if (held_v_q) begin
          res_valid_d = 1'b1;
          res_last_d  = 1'b1;
          res_d       = held_q;
        end
        held_v_d = 1'b0;
        state_d  = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    if (produce) begin
      if (held_v_q) begin
        res_valid_d = 1'b1;
        res_d       = held_q;
      end
      held_d   = nr;
      held_v_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sec_q        <= '0;
      valid_q      <= '0;
      written_q    <= '0;
      pvalid_q     <= '0;
      found_free_q <= 1'b0;
      mode_tx_q    <= 1'b0;
      held_v_q     <= 1'b0;
      res_valid_q  <= 1'b0;
      res_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      sec_q        <= sec_d;
      valid_q      <= valid_d;
      written_q    <= written_d;
      pvalid_q     <= pvalid_d;
      found_free_q <= found_free_d;
      mode_tx_q    <= mode_tx_d;
      held_v_q     <= held_v_d;
      res_valid_q  <= res_valid_d;
      res_last_q   <= res_last_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    tidx_q       <= tidx_d;
    qidx_q       <= qidx_d;
    free_slot_q  <= free_slot_d;
    oldest_q     <= oldest_d;
    oldest_age_q <= oldest_age_d;
    key_q        <= key_d;
    sip_q        <= sip_d;
    smac_q       <= smac_d;
    aip_q        <= aip_d;
    is_req_q     <= is_req_d;
    ptag_q       <= ptag_d;
    pproto_q     <= pproto_d;
    held_q       <= held_d;
    res_q        <= res_d;
  end

  // Outputs.
  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign kind_o         = res_q.kind;
  assign out_mac_o      = res_q.mac;
  assign out_ip_o       = res_q.ip;
  assign out_tag_o      = res_q.tag;
  assign out_protocol_o = res_q.protocol;
  assign last_o         = res_last_q;

endmodule
